FILE: hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// property checked on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/glmd_pkg.sv
// types, widths and helpers of the grid local minimum detector
package glmd_pkg;

  localparam int unsigned HGT_W        = 4;
  localparam int unsigned ROW_OUT_W    = 10;
  localparam int unsigned COL_OUT_W    = 9;
  localparam int unsigned RISK_W       = 24;
  localparam int unsigned GW_W         = 10;
  localparam int unsigned GR_W         = 11;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 11;
  localparam int unsigned WORD_W       = 2 * HGT_W;
  localparam int unsigned FIFO_DEPTH   = 4;
  localparam int unsigned FIFO_PTR_W   = 2;
  localparam int unsigned FIFO_CNT_W   = 3;
  localparam int unsigned RES_PER_ITEM = 3;

  localparam logic [GW_W-1:0]  GRID_WIDTH_RST  = 10'd512;
  localparam logic [GR_W-1:0]  GRID_ROWS_RST   = 11'd1024;
  localparam logic [HGT_W-1:0] WALL_HEIGHT_RST = 4'd9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_ROWS   = 2'd1,
    CFG_WALL_HEIGHT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [ROW_OUT_W-1:0] row;
    logic [COL_OUT_W-1:0] col;
    logic [HGT_W-1:0]     height;
    logic                 is_low;
    logic                 last;
    logic                 done;
  } result_t;

  // strict minimum over the neighbours that are flagged valid, never at the wall height
  function automatic logic judge(
    input logic [HGT_W-1:0] hgt,
    input logic [HGT_W-1:0] wall,
    input logic             up_v,
    input logic [HGT_W-1:0] up_h,
    input logic             dn_v,
    input logic [HGT_W-1:0] dn_h,
    input logic             lf_v,
    input logic [HGT_W-1:0] lf_h,
    input logic             rt_v,
    input logic [HGT_W-1:0] rt_h
  );
    return (hgt != wall) && !(up_v && (hgt >= up_h)) && !(dn_v && (hgt >= dn_h)) &&
           !(lf_v && (hgt >= lf_h)) && !(rt_v && (hgt >= rt_h));
  endfunction

endpackage

FILE: hdl/grid_local_minimum_detector.sv
// top level: 4-neighbour local minimum detector on a raster height stream
//
//  channel   direction  handshake                 payload
//  config    in         cfg_we_i                  cfg_index_i, cfg_data_i
//  sample    in         in_valid_i / in_ready_o   sample_height_i
//  result    out        out_valid_o / out_ready_i cell_row_o .. grid_done_o
//
// one sample per cycle while in_ready_o is high; the line store is read ahead into
// a register for the next position and written back in the cycle the sample is taken
// results leave a 4-entry queue one per cycle while out_ready_i is high
// a last-row sample can add up to three results, so on that row the input can stall
// in_ready_o is high while at most one result is queued, so out_ready_i stalls back up
// reset clears control state only; the line store needs no clearing pass
module grid_local_minimum_detector #(
  parameter int unsigned MAX_WIDTH = 512,
  parameter int unsigned MAX_ROWS  = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [glmd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [glmd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [glmd_pkg::HGT_W-1:0]          sample_height_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [glmd_pkg::ROW_OUT_W-1:0]      cell_row_o,
  output logic [glmd_pkg::COL_OUT_W-1:0]      cell_col_o,
  output logic [glmd_pkg::HGT_W-1:0]          cell_height_o,
  output logic                                is_low_o,
  output logic [glmd_pkg::RISK_W-1:0]         risk_sum_o,
  output logic                                last_of_run_o,
  output logic                                grid_done_o
);

  localparam int unsigned COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned EW_W  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned ER_W  = $clog2(MAX_ROWS + 1);
  localparam int unsigned HGT_W = glmd_pkg::HGT_W;
  localparam int unsigned WORD_W = glmd_pkg::WORD_W;
  localparam int unsigned RISK_W = glmd_pkg::RISK_W;

  // ---------------------------------------------------------------- config
  logic [glmd_pkg::GW_W-1:0] grid_width_q;
  logic [glmd_pkg::GR_W-1:0] grid_rows_q;
  logic [HGT_W-1:0]          wall_q;
  logic                      cfg_hit;
  logic [EW_W-1:0]           eff_w;
  logic [ER_W-1:0]           eff_r;

  always_comb begin
    case (cfg_index_i)
      glmd_pkg::CFG_GRID_WIDTH:  cfg_hit = cfg_we_i;
      glmd_pkg::CFG_GRID_ROWS:   cfg_hit = cfg_we_i;
      glmd_pkg::CFG_WALL_HEIGHT: cfg_hit = cfg_we_i;
      default:                   cfg_hit = 1'b0;
    endcase
  end

  // sizes saturate into 1..max
  always_comb begin
    if (grid_width_q == '0) begin
      eff_w = EW_W'(1);
    end else if (32'(grid_width_q) > MAX_WIDTH) begin
      eff_w = EW_W'(MAX_WIDTH);
    end else begin
      eff_w = EW_W'(grid_width_q);
    end
    if (grid_rows_q == '0) begin
      eff_r = ER_W'(1);
    end else if (32'(grid_rows_q) > MAX_ROWS) begin
      eff_r = ER_W'(MAX_ROWS);
    end else begin
      eff_r = ER_W'(grid_rows_q);
    end
  end

  // ---------------------------------------------------------------- position
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d, row_m1;
  logic [EW_W-1:0]  col_inc, col_d_inc;
  logic [ER_W-1:0]  row_inc;
  logic             col_last, row_last;
  logic             row_ge1, row_ge2, col_ge1, col_ge2;
  logic             in_accept;

  assign in_accept = in_valid_i && in_ready_o;
  assign col_inc   = EW_W'(col_q) + EW_W'(1);
  assign row_inc   = ER_W'(row_q) + ER_W'(1);
  assign col_last  = (col_inc == eff_w);
  assign row_last  = (row_inc == eff_r);
  assign row_ge1   = (row_q != '0);
  assign row_ge2   = (row_q > ROW_W'(1));
  assign col_ge1   = (col_q != '0);
  assign col_ge2   = (col_q > COL_W'(1));
  assign row_m1    = row_q - ROW_W'(1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_hit) begin
      // any write to a defined register restarts the grid
      col_d = '0;
      row_d = '0;
    end else if (in_accept) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : ROW_W'(row_inc);
      end else begin
        col_d = COL_W'(col_inc);
      end
    end
  end

  // ---------------------------------------------------------------- line store
  // one word per column: low nibble holds the even row, high nibble the odd row,
  // so one read gives the row above and the row two above
  logic [WORD_W-1:0] line_mem [MAX_WIDTH];
  logic [WORD_W-1:0] rd_a_q, rd_b_q;
  logic [COL_W-1:0]  rd_addr_b, rd_addr_b_q;
  logic              fwd_valid_q;
  logic [COL_W-1:0]  fwd_addr_q;
  logic [WORD_W-1:0] fwd_word_q;
  logic [WORD_W-1:0] word_a, word_b, wr_word;
  logic [HGT_W-1:0]  x_up, up2, rval, hgt;
  logic              par;

  // read ahead for the position of the next sample
  assign col_d_inc = EW_W'(col_d) + EW_W'(1);
  assign rd_addr_b = (col_d_inc < eff_w) ? COL_W'(col_d_inc) : '0;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      line_mem[col_q] <= wr_word;
    end
    rd_a_q      <= line_mem[col_d];
    rd_b_q      <= line_mem[rd_addr_b];
    rd_addr_b_q <= rd_addr_b;
  end

  // the write at the same edge as the read is not in the read data: forward it
  assign word_a = (fwd_valid_q && (fwd_addr_q == col_q)) ? fwd_word_q : rd_a_q;
  assign word_b = (fwd_valid_q && (fwd_addr_q == rd_addr_b_q)) ? fwd_word_q : rd_b_q;

  assign hgt  = sample_height_i;
  assign par  = row_q[0];
  assign x_up = par ? word_a[HGT_W-1:0] : word_a[WORD_W-1:HGT_W];
  assign up2  = par ? word_a[WORD_W-1:HGT_W] : word_a[HGT_W-1:0];
  assign rval = par ? word_b[HGT_W-1:0] : word_b[WORD_W-1:HGT_W];
  // current row goes into its own nibble, the row above is kept
  assign wr_word = par ? {hgt, x_up} : {x_up, hgt};

  always_ff @(posedge clk_i) begin
    fwd_addr_q <= col_q;
    fwd_word_q <= wr_word;
  end

  // neighbours to the left come from the previous samples of this row
  logic [HGT_W-1:0] prev_x_q, prev_h_q, prev2_h_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      prev_x_q  <= x_up;
      prev_h_q  <= hgt;
      prev2_h_q <= prev_h_q;
    end
  end

  // ---------------------------------------------------------------- verdicts
  glmd_pkg::result_t                     res [glmd_pkg::RES_PER_ITEM];
  logic [glmd_pkg::RES_PER_ITEM-1:0]     res_en;

  always_comb begin
    res_en[0] = row_ge1;
    res_en[1] = row_last && col_ge1;
    res_en[2] = row_last && col_last;

    // cell above the sample
    res[0].row    = glmd_pkg::ROW_OUT_W'(row_m1);
    res[0].col    = glmd_pkg::COL_OUT_W'(col_q);
    res[0].height = x_up;
    res[0].is_low = glmd_pkg::judge(x_up, wall_q, row_ge2, up2, 1'b1, hgt,
                                    col_ge1, prev_x_q, !col_last, rval);
    res[0].last   = !res_en[1] && !res_en[2];
    res[0].done   = 1'b0;

    // last row: cell left of the sample
    res[1].row    = glmd_pkg::ROW_OUT_W'(row_q);
    res[1].col    = glmd_pkg::COL_OUT_W'(col_q - COL_W'(1));
    res[1].height = prev_h_q;
    res[1].is_low = glmd_pkg::judge(prev_h_q, wall_q, row_ge1, prev_x_q, 1'b0, '0,
                                    col_ge2, prev2_h_q, 1'b1, hgt);
    res[1].last   = !res_en[2];
    res[1].done   = 1'b0;

    // last row, last column: the sample itself closes the grid
    res[2].row    = glmd_pkg::ROW_OUT_W'(row_q);
    res[2].col    = glmd_pkg::COL_OUT_W'(col_q);
    res[2].height = hgt;
    res[2].is_low = glmd_pkg::judge(hgt, wall_q, row_ge1, x_up, 1'b0, '0,
                                    col_ge1, prev_h_q, 1'b0, '0);
    res[2].last   = 1'b1;
    res[2].done   = 1'b1;
  end

  // ---------------------------------------------------------------- result queue
  glmd_pkg::result_t                fifo_q [glmd_pkg::FIFO_DEPTH];
  glmd_pkg::result_t                fifo_d [glmd_pkg::FIFO_DEPTH];
  glmd_pkg::result_t                head;
  logic [glmd_pkg::FIFO_PTR_W-1:0]  wr_ptr_q, rd_ptr_q, wr_off, wr_idx;
  logic [glmd_pkg::FIFO_CNT_W-1:0]  count_q;
  logic                             pop;

  // up to three results enter packed at the write pointer
  always_comb begin
    fifo_d = fifo_q;
    wr_off = '0;
    wr_idx = wr_ptr_q;
    if (in_accept) begin
      for (int k = 0; k < glmd_pkg::RES_PER_ITEM; k++) begin
        if (res_en[k]) begin
          wr_idx         = wr_ptr_q + wr_off;
          fifo_d[wr_idx] = res[k];
          wr_off         = wr_off + glmd_pkg::FIFO_PTR_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fifo_q <= fifo_d;
  end

  assign head        = fifo_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != '0);
  // room for a full run of results
  assign in_ready_o  = (count_q <=
                        glmd_pkg::FIFO_CNT_W'(glmd_pkg::FIFO_DEPTH - glmd_pkg::RES_PER_ITEM));

  // ---------------------------------------------------------------- risk sum
  // accumulated at the queue head, so the total follows delivered results in order
  logic [RISK_W-1:0] risk_acc_q, risk_head;
  logic [HGT_W:0]    risk_add;
  logic [RISK_W:0]   risk_wide;

  assign risk_add  = {1'b0, head.height} + (HGT_W + 1)'(1);
  assign risk_wide = {1'b0, risk_acc_q} + (RISK_W + 1)'(risk_add);
  assign risk_head = !head.is_low ? risk_acc_q :
                     (risk_wide[RISK_W] ? '1 : risk_wide[RISK_W-1:0]);

  assign cell_row_o    = head.row;
  assign cell_col_o    = head.col;
  assign cell_height_o = head.height;
  assign is_low_o      = head.is_low;
  assign risk_sum_o    = risk_head;
  assign last_of_run_o = head.last;
  assign grid_done_o   = head.done;

  // ---------------------------------------------------------------- control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q <= glmd_pkg::GRID_WIDTH_RST;
      grid_rows_q  <= glmd_pkg::GRID_ROWS_RST;
      wall_q       <= glmd_pkg::WALL_HEIGHT_RST;
      col_q        <= '0;
      row_q        <= '0;
      fwd_valid_q  <= 1'b0;
      wr_ptr_q     <= '0;
      rd_ptr_q     <= '0;
      count_q      <= '0;
      risk_acc_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          glmd_pkg::CFG_GRID_WIDTH:  grid_width_q <= cfg_data_i[glmd_pkg::GW_W-1:0];
          glmd_pkg::CFG_GRID_ROWS:   grid_rows_q  <= cfg_data_i[glmd_pkg::GR_W-1:0];
          glmd_pkg::CFG_WALL_HEIGHT: wall_q       <= cfg_data_i[HGT_W-1:0];
          default: ;
        endcase
      end
      col_q       <= col_d;
      row_q       <= row_d;
      fwd_valid_q <= in_accept;
      wr_ptr_q    <= wr_ptr_q + wr_off;
      rd_ptr_q    <= rd_ptr_q + glmd_pkg::FIFO_PTR_W'(pop);
      count_q     <= count_q + glmd_pkg::FIFO_CNT_W'(wr_off) - glmd_pkg::FIFO_CNT_W'(pop);
      if (cfg_hit) begin
        risk_acc_q <= '0;
      end else if (pop) begin
        // total restarts after the grid's final cell
        risk_acc_q <= head.done ? '0 : risk_head;
      end
    end
  end

endmodule

FILE: hdl/glmd_checker.sv
// port-level assertions of the grid local minimum detector and their bind
`include "assert_macros.svh"

module glmd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [glmd_pkg::ROW_OUT_W-1:0] cell_row_o,
  input logic [glmd_pkg::COL_OUT_W-1:0] cell_col_o,
  input logic [glmd_pkg::HGT_W-1:0]     cell_height_o,
  input logic                           is_low_o,
  input logic [glmd_pkg::RISK_W-1:0]    risk_sum_o,
  input logic                           last_of_run_o,
  input logic                           grid_done_o
);

  localparam int unsigned OUT_W = glmd_pkg::ROW_OUT_W + glmd_pkg::COL_OUT_W +
                                  glmd_pkg::HGT_W + glmd_pkg::RISK_W + 4;

  logic [OUT_W-1:0] out_bus;
  logic             out_stall;
  logic             out_done;
  logic             out_low;

  // valid and every payload field of the result channel
  assign out_bus   = {out_valid_o, cell_row_o, cell_col_o, cell_height_o, is_low_o,
                      risk_sum_o, last_of_run_o, grid_done_o};
  assign out_stall = out_valid_o && !out_ready_i;
  assign out_done  = out_valid_o && grid_done_o;
  assign out_low   = out_valid_o && is_low_o;

  // a stalled result holds
  `ASSERT_IMP(a_out_hold, clk_i, rst_ni, (out_stall |=> $stable(out_bus)), "stalled result changed")

  // the grid's final cell closes its run
  `ASSERT_IMP(a_done_last, clk_i, rst_ni, (out_done |-> last_of_run_o), "done not last")

  // a low cell always shows a nonzero total
  `ASSERT_IMP(a_low_risk, clk_i, rst_ni, (out_low |-> risk_sum_o != '0), "low cell zero risk")

  // nothing is offered in the cycle after reset is seen
  `ASSERT_ALWAYS(a_rst_quiet, clk_i, (!rst_ni |=> !out_valid_o), "result offered after reset")

endmodule

bind grid_local_minimum_detector glmd_checker u_glmd_checker (.*);

FILE: test/testbench.sv
// self-checking testbench of the grid local minimum detector
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned GRID_MAX_W    = 512;
  localparam int unsigned GRID_MAX_R    = 1024;
  localparam int unsigned RISK_CAP      = 24'hFFFFFF;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  // index with no register behind it: a write there must not restart the grid
  localparam logic [glmd_pkg::CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;

  // one verdict as it leaves the block, fields in port order
  typedef struct packed {
    logic [glmd_pkg::ROW_OUT_W-1:0] row;
    logic [glmd_pkg::COL_OUT_W-1:0] col;
    logic [glmd_pkg::HGT_W-1:0]     height;
    logic                           is_low;
    logic [glmd_pkg::RISK_W-1:0]    risk;
    logic                           last;
    logic                           done;
  } cell_verdict_t;

  logic                            clk_i           = 1'b0;
  logic                            rst_ni          = 1'b0;
  logic                            cfg_we_i        = 1'b0;
  logic [glmd_pkg::CFG_IDX_W-1:0]  cfg_index_i     = '0;
  logic [glmd_pkg::CFG_DATA_W-1:0] cfg_data_i      = '0;
  logic                            in_valid_i      = 1'b0;
  logic                            in_ready_o;
  logic [glmd_pkg::HGT_W-1:0]      sample_height_i = '0;
  logic                            out_valid_o;
  logic                            out_ready_i     = 1'b0;
  logic [glmd_pkg::ROW_OUT_W-1:0]  cell_row_o;
  logic [glmd_pkg::COL_OUT_W-1:0]  cell_col_o;
  logic [glmd_pkg::HGT_W-1:0]      cell_height_o;
  logic                            is_low_o;
  logic [glmd_pkg::RISK_W-1:0]     risk_sum_o;
  logic                            last_of_run_o;
  logic                            grid_done_o;

  grid_local_minimum_detector #(
    .MAX_WIDTH(GRID_MAX_W),
    .MAX_ROWS (GRID_MAX_R)
  ) dut (.*);

  // idle rates in percent, and a long output hold-off counted down by the checker
  int unsigned tx_idle_pct    = 34;
  int unsigned rx_idle_pct    = 83;
  int unsigned rx_hold_cycles = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // ---------------------------------------------------------------------------
  // predictor state: settings, two-row line store, scan position, risk total
  // ---------------------------------------------------------------------------
  logic [glmd_pkg::GW_W-1:0]  width_setting = glmd_pkg::GRID_WIDTH_RST;
  logic [glmd_pkg::GR_W-1:0]  rows_setting  = glmd_pkg::GRID_ROWS_RST;
  logic [glmd_pkg::HGT_W-1:0] wall_setting  = glmd_pkg::WALL_HEIGHT_RST;
  bit   [glmd_pkg::HGT_W-1:0] line_store [2][GRID_MAX_W];
  int unsigned                scan_row      = 0;
  int unsigned                scan_col      = 0;
  int unsigned                risk_acc      = 0;

  cell_verdict_t verdict_queue [$];

  // register values outside the legal range saturate to the nearest end
  function automatic int unsigned active_width();
    if (width_setting == '0) return 1;
    if (width_setting > GRID_MAX_W) return GRID_MAX_W;
    return 32'(width_setting);
  endfunction

  function automatic int unsigned active_rows();
    if (rows_setting == '0) return 1;
    if (rows_setting > GRID_MAX_R) return GRID_MAX_R;
    return 32'(rows_setting);
  endfunction

  // strict 4-neighbour minimum; a neighbour outside the grid does not count, a wall cell is never low
  function automatic bit strictly_lowest(
    input logic [glmd_pkg::HGT_W-1:0] h,
    input bit up_ok, input logic [glmd_pkg::HGT_W-1:0] up,
    input bit dn_ok, input logic [glmd_pkg::HGT_W-1:0] dn,
    input bit lf_ok, input logic [glmd_pkg::HGT_W-1:0] lf,
    input bit rt_ok, input logic [glmd_pkg::HGT_W-1:0] rt
  );
    if (h == wall_setting) return 1'b0;
    return !(up_ok && h >= up) && !(dn_ok && h >= dn) &&
           !(lf_ok && h >= lf) && !(rt_ok && h >= rt);
  endfunction

  // builds one verdict and folds a low cell into the saturating risk total
  function automatic cell_verdict_t record_verdict(
    input int unsigned row, input int unsigned col,
    input logic [glmd_pkg::HGT_W-1:0] h, input bit low, input bit done
  );
    cell_verdict_t v;
    int unsigned   gain;
    gain = 32'(h) + 1;
    if (low) risk_acc = (risk_acc > RISK_CAP - gain) ? RISK_CAP : risk_acc + gain;
    v.row    = row[glmd_pkg::ROW_OUT_W-1:0];
    v.col    = col[glmd_pkg::COL_OUT_W-1:0];
    v.height = h;
    v.is_low = low;
    v.risk   = risk_acc[glmd_pkg::RISK_W-1:0];
    v.last   = 1'b0;
    v.done   = done;
    return v;
  endfunction

  // verdicts released by one accepted sample, queued in raster order
  task automatic predict_verdicts(input logic [glmd_pkg::HGT_W-1:0] h);
    int unsigned                w, nrows, r, c, cur, prv, n, i;
    logic [glmd_pkg::HGT_W-1:0] two_up, x, up, lf, rt;
    bit                         done;
    cell_verdict_t              run [3];
    w     = active_width();
    nrows = active_rows();
    r     = scan_row;
    c     = scan_col;
    cur   = r & 1;
    prv   = (r + 1) & 1;
    n     = 0;
    done  = 1'b0;
    if (r >= nrows || c >= w) begin
      r   = 0;
      c   = 0;
      cur = 0;
      prv = 1;
    end
    // same-parity row holds row r-2; read it before the new sample overwrites it
    two_up = line_store[cur][c];
    // the row above is now complete below: judge the cell just above this sample
    if (r >= 1) begin
      x  = line_store[prv][c];
      lf = (c >= 1) ? line_store[prv][c-1] : '0;
      rt = (c + 1 < w) ? line_store[prv][c+1] : '0;
      run[n] = record_verdict(r - 1, c, x,
                 strictly_lowest(x, r >= 2, two_up, 1'b1, h, c >= 1, lf, c + 1 < w, rt),
                 1'b0);
      n++;
    end
    line_store[cur][c] = h;
    // last row has nothing below: the left neighbour is known once its right arrives
    if (r == nrows - 1) begin
      if (c >= 1) begin
        x  = line_store[cur][c-1];
        up = (r >= 1) ? line_store[prv][c-1] : '0;
        lf = (c >= 2) ? line_store[cur][c-2] : '0;
        run[n] = record_verdict(r, c - 1, x,
                   strictly_lowest(x, r >= 1, up, 1'b0, '0, c >= 2, lf, 1'b1, h), 1'b0);
        n++;
      end
      // final cell of the grid judges itself
      if (c == w - 1) begin
        up = (r >= 1) ? line_store[prv][c] : '0;
        lf = (c >= 1) ? line_store[cur][c-1] : '0;
        run[n] = record_verdict(r, c, h,
                   strictly_lowest(h, r >= 1, up, 1'b0, '0, c >= 1, lf, 1'b0, '0), 1'b1);
        n++;
        done = 1'b1;
      end
    end
    if (n > 0) run[n-1].last = 1'b1;
    for (i = 0; i < n; i++) verdict_queue = {verdict_queue, run[i]};
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= nrows) r = 0;
    end
    scan_row = r;
    scan_col = c;
    if (done) risk_acc = 0;
  endtask

  // ---------------------------------------------------------------------------
  // clock, run limit
  // ---------------------------------------------------------------------------
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side: check every transaction, then decide next cycle's ready
  // ---------------------------------------------------------------------------
  function automatic string describe(input cell_verdict_t v);
    return $sformatf("row %0d col %0d height %0d low %0b risk %0d last %0b done %0b",
                     v.row, v.col, v.height, v.is_low, v.risk, v.last, v.done);
  endfunction

  initial begin : result_checker
    cell_verdict_t got, want;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got = {cell_row_o, cell_col_o, cell_height_o, is_low_o, risk_sum_o,
               last_of_run_o, grid_done_o};
        if (verdict_queue.size() == 0) begin
          if (mismatch_count < MAX_REPORTS)
            $display("unexpected result: %s", describe(got));
          mismatch_count++;
        end else begin
          want = verdict_queue.pop_front();
          if (got !== want) begin
            if (mismatch_count < MAX_REPORTS) begin
              $display("result mismatch");
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(got));
            end
            mismatch_count++;
          end
        end
      end
      // a pending hold-off wins over the random stall pattern
      if (rx_hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        rx_hold_cycles--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sample side and register writes; every task starts and ends just after an edge
  // ---------------------------------------------------------------------------
  task automatic send_sample(input logic [glmd_pkg::HGT_W-1:0] h);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    sample_height_i <= h;
    do @(posedge clk_i); while (!in_ready_o);
    predict_verdicts(h);
  endtask

  // drop valid, let every expected verdict out, then allow row-0 samples to settle
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (verdict_queue.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [glmd_pkg::CFG_IDX_W-1:0] idx,
                                input logic [glmd_pkg::CFG_DATA_W-1:0] value);
    bit restart;
    wait_for_results();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    restart = 1'b1;
    case (idx)
      glmd_pkg::CFG_GRID_WIDTH:  width_setting = value[glmd_pkg::GW_W-1:0];
      glmd_pkg::CFG_GRID_ROWS:   rows_setting  = value[glmd_pkg::GR_W-1:0];
      glmd_pkg::CFG_WALL_HEIGHT: wall_setting  = value[glmd_pkg::HGT_W-1:0];
      default:                   restart = 1'b0;
    endcase
    // any real register write starts a fresh grid; the line store is kept
    if (restart) begin
      scan_row = 0;
      scan_col = 0;
      risk_acc = 0;
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_grid(input logic [glmd_pkg::CFG_DATA_W-1:0] w,
                          input logic [glmd_pkg::CFG_DATA_W-1:0] rows,
                          input logic [glmd_pkg::CFG_DATA_W-1:0] wall);
    write_register(glmd_pkg::CFG_GRID_WIDTH, w);
    write_register(glmd_pkg::CFG_GRID_ROWS, rows);
    write_register(glmd_pkg::CFG_WALL_HEIGHT, wall);
  endtask

  function automatic logic [glmd_pkg::HGT_W-1:0] pick_height(input int unsigned base,
                                                             input int unsigned span);
    return glmd_pkg::HGT_W'(base + $urandom_range(span));
  endfunction

  function automatic logic [glmd_pkg::CFG_DATA_W-1:0] pick_wall();
    return glmd_pkg::CFG_DATA_W'($urandom_range(15));
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // zero sizes saturate to a 1x1 grid: every sample is its own grid, low unless wall
  task automatic test_single_cells();
    set_grid(11'd0, 11'd0, 11'd0);
    send_sample(4'd0);
    send_sample(4'd15);
    send_sample(4'd7);
    write_register(glmd_pkg::CFG_WALL_HEIGHT, 11'd15);
    send_sample(4'd15);
    send_sample(4'd1);
  endtask

  // 3x3 with a tie in the corner, an interior minimum, and a wall cell that
  // would otherwise be low
  task automatic test_small_grid();
    logic [glmd_pkg::HGT_W-1:0] heights [9] = '{4'd5, 4'd5, 4'd7, 4'd8, 4'd0, 4'd15,
                                                4'd3, 4'd9, 4'd1};
    set_grid(11'd3, 11'd3, 11'd1);
    foreach (heights[i]) send_sample(heights[i]);
  endtask

  // a register write in the middle of a grid starts over from row 0
  task automatic test_grid_restart();
    set_grid(11'd2, 11'd3, 11'd9);
    repeat (3) send_sample(pick_height(0, 15));
    write_register(glmd_pkg::CFG_WALL_HEIGHT, 11'd4);
    repeat (6) send_sample(pick_height(0, 15));
  endtask

  // a write to the unused index changes nothing, the grid carries on
  task automatic test_spare_index();
    set_grid(11'd2, 11'd2, 11'd9);
    send_sample(4'd6);
    send_sample(4'd2);
    write_register(CFG_SPARE_INDEX, '1);
    send_sample(4'd3);
    send_sample(4'd8);
  endtask

  // width bits above the register are dropped: 0x400 reads as zero, so width 1
  task automatic test_width_masking();
    set_grid(11'h400, 11'd2, 11'd9);
    send_sample(4'd1);
    send_sample(4'd12);
  endtask

  // oversize values: a very long row and a very tall grid, both cut short
  // and restarted by the next setting
  task automatic test_size_extremes();
    set_grid(11'h3FF, 11'd1, pick_wall());
    repeat (24) send_sample(pick_height(0, 15));
    set_grid(11'd2, 11'h7FF, pick_wall());
    repeat (24) send_sample(pick_height(0, 15));
  endtask

  // random grids, mostly small, full grids with random content; some are cut
  // short and restarted by the next setting
  task automatic test_random_grids(input int unsigned tx_pct, input int unsigned rx_pct,
                                   input int unsigned budget);
    int unsigned fed, w, rows, cells, count, base, span;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    fed = 0;
    while (fed < budget) begin
      case ($urandom_range(9))
        0:       w = 0;
        1:       w = $urandom_range(9, 16);
        default: w = $urandom_range(1, 6);
      endcase
      rows = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 5);
      set_grid(glmd_pkg::CFG_DATA_W'(w), glmd_pkg::CFG_DATA_W'(rows), pick_wall());
      cells = active_width() * active_rows();
      count = ($urandom_range(3) == 0) ? $urandom_range(1, cells)
                                       : cells * $urandom_range(1, 2);
      // narrow height bands give plenty of ties and near-ties
      span = ($urandom_range(3) == 0) ? 15 : $urandom_range(1, 4);
      base = $urandom_range(15 - span);
      repeat (count) send_sample(pick_height(base, span));
      fed += count;
    end
    wait_for_results();
  endtask

  // long output hold-off while samples keep coming: queue fills, input stalls;
  // then the sender waits for everything before sending another full grid
  task automatic test_output_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_grid(11'd5, 11'd4, pick_wall());
    rx_hold_cycles = 200;
    repeat (40) send_sample(pick_height(0, 15));
    wait_for_results();
    repeat (20) send_sample(pick_height(0, 15));
    wait_for_results();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_cells();
    test_small_grid();
    test_grid_restart();
    test_spare_index();
    test_width_masking();
    test_size_extremes();
    test_random_grids(34, 83, 110);
    test_random_grids(83, 34, 110);
    test_output_backpressure();
    test_random_grids(0, 0, 110);

    wait_for_results();
    repeat (4 * SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && verdict_queue.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/glmd_pkg.sv
hdl/grid_local_minimum_detector.sv
hdl/glmd_checker.sv
test/testbench.sv
